>>> rtl/ubd_pkg.sv
// Package with the constants, payload types and pipeline stage type of the baud divisor.
`default_nettype none
package ubd_pkg;

  localparam int MANTISSA_BITS = 12;
  localparam int QUOT_W = MANTISSA_BITS + 4;
  localparam int CLK_W = 32;
  localparam int BAUD_W = 24;
  localparam int DVS_W = BAUD_W + 1;
  localparam int CMP_W = DVS_W + QUOT_W;
  localparam int MANT_W = 12;
  localparam int FRAC_W = 4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAUD_ZERO = 2'd1,
    STATUS_BELOW_ONE = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CLK_W-1:0]  clock_hz;
    logic [BAUD_W-1:0] baud_bps;
    logic              oversample_by_8;
  } in_t;

  typedef struct packed {
    logic [MANT_W-1:0] divisor_mantissa;
    logic [FRAC_W-1:0] divisor_fraction;
    status_t           status;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [CMP_W-1:0]  rem;
    logic [CMP_W-1:0]  dsh;
    logic [QUOT_W-1:0] quot;
    logic              osr8;
    logic              baud_zero;
    logic              ovf;
  } div_stage_t;

endpackage
`default_nettype wire

>>> rtl/ubd_prep.sv
// Front stage: forms the rounded numerator and divisor and detects zero baud and overflow.
`default_nettype none
module ubd_prep
  import ubd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire in_t        request,
  output div_stage_t      stage
);

  logic [CMP_W-1:0] num;
  logic [CMP_W-1:0] dvs;
  logic [CMP_W-1:0] thr;

  always_comb begin
    num = (CMP_W'(request.clock_hz) << 1) + CMP_W'(request.baud_bps);
    dvs = CMP_W'({request.baud_bps, 1'b0});
    if (request.oversample_by_8) begin
      thr = dvs << (QUOT_W - 1);
    end else begin
      thr = dvs << QUOT_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= load;
    end
    stage.rem       <= num;
    stage.dsh       <= dvs << (QUOT_W - 1);
    stage.quot      <= '0;
    stage.osr8      <= request.oversample_by_8;
    stage.baud_zero <= (request.baud_bps == '0);
    stage.ovf       <= (num >= thr);
  end

endmodule
`default_nettype wire

>>> rtl/ubd_div_stage.sv
// One restoring division step that settles one quotient bit.
`default_nettype none
module ubd_div_stage
  import ubd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire div_stage_t stage_in,
  output div_stage_t      stage_out
);

  logic             fits;
  logic [CMP_W-1:0] rem_next;

  always_comb begin
    fits = (stage_in.rem >= stage_in.dsh);
    rem_next = fits ? (stage_in.rem - stage_in.dsh) : stage_in.rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.rem       <= rem_next;
    stage_out.dsh       <= stage_in.dsh >> 1;
    stage_out.quot      <= {stage_in.quot[QUOT_W-2:0], fits};
    stage_out.osr8      <= stage_in.osr8;
    stage_out.baud_zero <= stage_in.baud_zero;
    stage_out.ovf       <= stage_in.ovf;
  end

endmodule
`default_nettype wire

>>> rtl/ubd_format.sv
// Output stage: splits the unit count into mantissa and fraction and sets the status.
`default_nettype none
module ubd_format
  import ubd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire div_stage_t stage,
  output logic            done,
  output out_t            result
);

  logic [MANTISSA_BITS-1:0] mant;
  logic [FRAC_W-1:0]        frac;
  out_t                     result_next;

  always_comb begin
    if (stage.osr8) begin
      mant = stage.quot[QUOT_W-2:3];
      frac = {1'b0, stage.quot[2:0]};
    end else begin
      mant = stage.quot[QUOT_W-1:4];
      frac = stage.quot[3:0];
    end
    if (stage.baud_zero) begin
      result_next.divisor_mantissa = '0;
      result_next.divisor_fraction = '0;
      result_next.status = STATUS_BAUD_ZERO;
    end else if (stage.ovf) begin
      result_next.divisor_mantissa = MANT_W'({MANTISSA_BITS{1'b1}});
      result_next.divisor_fraction = stage.osr8 ? FRAC_W'(7) : FRAC_W'(15);
      result_next.status = STATUS_OVERFLOW;
    end else begin
      result_next.divisor_mantissa = MANT_W'(mant);
      result_next.divisor_fraction = frac;
      result_next.status = (mant == '0) ? STATUS_BELOW_ONE : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
    result <= result_next;
  end

endmodule
`default_nettype wire

>>> rtl/uart_baud_divisor.sv
// Top level of the pipelined UART baud divisor calculator.
//
// A request is taken in every cycle in which start is high; busy is always low. Each request
// gives one result on the result port, marked by done for one cycle. The request passes a
// front register that forms the rounded numerator and checks for overflow, then a 16-stage
// restoring divider (mantissa width plus four) that settles one quotient bit per stage, and
// then an output register that formats the mantissa, fraction and status. The receiver cannot
// stall, and results leave in the order in which requests were taken.
`default_nettype none
module uart_baud_divisor
  import ubd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  request,
  output logic      done,
  output out_t      result
);

  div_stage_t stages [QUOT_W+1];

  assign busy = 1'b0;

  ubd_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .load    (start),
    .request (request),
    .stage   (stages[0])
  );

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    ubd_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (stages[i]),
      .stage_out (stages[i+1])
    );
  end

  ubd_format u_format (
    .clk    (clk),
    .rst    (rst),
    .stage  (stages[QUOT_W]),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the UART baud divisor: directed corner cases and random traffic.
module tb_top;
  import ubd_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned DRAIN_CYCLES = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  request = '0;
  logic done;
  out_t result;

  out_t        pending_divisors[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  uart_baud_divisor dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_t make_request(input logic [31:0] clock_hz, input logic [23:0] baud,
                                       input logic osr8);
    in_t req;
    req.clock_hz = clock_hz;
    req.baud_bps = baud;
    req.oversample_by_8 = osr8;
    return req;
  endfunction

  // Rounded divisor in fraction units, split into mantissa and fraction.
  function automatic out_t predict_divisor(input in_t req);
    longint unsigned clock64;
    longint unsigned baud64;
    longint unsigned osr;
    longint unsigned units;
    longint unsigned mant;
    longint unsigned frac;
    longint unsigned mant_max;
    out_t res;
    clock64 = req.clock_hz;
    baud64 = req.baud_bps;
    osr = req.oversample_by_8 ? 64'd8 : 64'd16;
    mant_max = (64'd1 << MANTISSA_BITS) - 64'd1;
    res = '0;
    if (baud64 == 0) begin
      res.status = STATUS_BAUD_ZERO;
      return res;
    end
    units = (2 * clock64 + baud64) / (2 * baud64);
    mant = units / osr;
    frac = units % osr;
    res.status = STATUS_OK;
    if (mant > mant_max) begin
      mant = mant_max;
      frac = osr - 1;
      res.status = STATUS_OVERFLOW;
    end else if (mant == 0) begin
      res.status = STATUS_BELOW_ONE;
    end
    res.divisor_mantissa = MANT_W'(mant);
    res.divisor_fraction = FRAC_W'(frac);
    return res;
  endfunction

  // Leaves start high after the transfer so that back-to-back requests need no toggle.
  task automatic send_request(input in_t item, input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99, 0) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      request <= make_request($urandom, 24'($urandom), 1'($urandom));
    end
    @(negedge clk);
    start <= 1'b1;
    request <= item;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_divisors.push_back(predict_divisor(item));
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_divisors.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual mant=%0d frac=%0d status=%0d",
                 $time, result.divisor_mantissa, result.divisor_fraction, result.status);
        mismatch_count++;
      end else begin
        want = pending_divisors.pop_front();
        if (done !== 1'b1 || result.divisor_mantissa !== want.divisor_mantissa) begin
          $display("%0t: mantissa expected %0d actual %0d", $time,
                   want.divisor_mantissa, result.divisor_mantissa);
          mismatch_count++;
        end
        if (result.divisor_fraction !== want.divisor_fraction) begin
          $display("%0t: fraction expected %0d actual %0d", $time,
                   want.divisor_fraction, result.divisor_fraction);
          mismatch_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_baud_zero();
    send_request(make_request(32'd0, 24'd0, 1'b0), 0);
    send_request(make_request(32'hFFFF_FFFF, 24'd0, 1'b1), 0);
  endtask

  task automatic test_below_one();
    send_request(make_request(32'd0, 24'd1, 1'b0), 0);
    send_request(make_request(32'd15, 24'd1, 1'b0), 0);
    send_request(make_request(32'd7, 24'd1, 1'b1), 0);
    send_request(make_request(32'd0, 24'hFF_FFFF, 1'b1), 0);
  endtask

  task automatic test_overflow();
    send_request(make_request(32'd65535, 24'd1, 1'b0), 0);
    send_request(make_request(32'd65536, 24'd1, 1'b0), 0);
    send_request(make_request(32'd32767, 24'd1, 1'b1), 0);
    send_request(make_request(32'd32768, 24'd1, 1'b1), 0);
    send_request(make_request(32'hFFFF_FFFF, 24'd1, 1'b0), 0);
    send_request(make_request(32'hFFFF_FFFF, 24'd1, 1'b1), 0);
  endtask

  // Fractions that round up to a whole unit must carry into the mantissa.
  task automatic test_rounding_carry();
    send_request(make_request(32'd31, 24'd2, 1'b0), 0);
    send_request(make_request(32'd15, 24'd2, 1'b1), 0);
    send_request(make_request(32'd3, 24'd2, 1'b0), 0);
    send_request(make_request(32'd5, 24'd4, 1'b0), 0);
  endtask

  task automatic test_field_extremes();
    send_request(make_request(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0), 0);
    send_request(make_request(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1), 0);
    send_request(make_request(32'd84_000_000, 24'd115_200, 1'b0), 0);
    send_request(make_request(32'd42_000_000, 24'd9_600, 1'b1), 0);
    send_request(make_request(32'hAAAA_AAAA, 24'h55_5555, 1'b0), 0);
  endtask

  // Mostly realistic clock and baud pairs aimed at rounding and overflow edges, plus noise.
  function automatic in_t random_request();
    in_t req;
    int unsigned kind;
    longint unsigned baud;
    longint unsigned osr;
    longint unsigned max_units;
    longint unsigned units;
    longint unsigned offset;
    longint unsigned clock64;
    kind = $urandom_range(7, 0);
    req = make_request($urandom, 24'($urandom), 1'($urandom));
    osr = req.oversample_by_8 ? 64'd8 : 64'd16;
    if (kind <= 1) return req;
    if (kind == 7) begin
      if ($urandom_range(3, 0) == 0) begin
        req.baud_bps = '0;
        return req;
      end
      baud = $urandom_range(255, 1);
      units = osr * 4096 + $urandom_range(32'(2 * osr), 0) - osr;
      offset = $urandom_range(32'(baud - 1), 0);
    end else begin
      baud = $urandom_range(24'hFF_FFFF, 1) >> $urandom_range(23, 0);
      if (baud == 0) baud = 1;
      max_units = 64'hFFFF_FFFF / baud;
      if (max_units > osr * 4097) max_units = osr * 4097;
      if ($urandom_range(1, 0) == 0 && max_units > 3 * osr) max_units = 3 * osr;
      units = $urandom_range(32'(max_units), 0);
      case ($urandom_range(3, 0))
        0: offset = (baud >= 2) ? baud / 2 - 1 : 0;
        1: offset = baud / 2;
        2: offset = (baud + 1) / 2;
        default: offset = $urandom_range(32'(baud - 1), 0);
      endcase
    end
    clock64 = units * baud + offset;
    if (clock64 > 64'hFFFF_FFFF) clock64 = 64'hFFFF_FFFF;
    req.clock_hz = clock64[31:0];
    req.baud_bps = baud[23:0];
    return req;
  endfunction

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    repeat (count) send_request(random_request(), idle_pct);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_baud_zero();
    test_below_one();
    test_overflow();
    test_rounding_carry();
    test_field_extremes();
    test_random_traffic(14, 560);
    test_random_traffic(45, 560);
    test_random_traffic(0, 560);
    @(negedge clk);
    start <= 1'b0;
    while (pending_divisors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
